// File: rtl/crrs_pkg.sv
// crrs_pkg: shared widths, reset values and register indexes for the
// cable retract/return sequencer; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package crrs_pkg;

   // default sizing
   localparam int MAX_CABLES_DEF  = 32;
   localparam int TABLE_DEPTH_DEF = 64;

   // field widths
   localparam int CABLE_W   = 5;
   localparam int LEN_W     = 32;
   localparam int DT_W      = 16;
   localparam int FRAC_W    = 17;
   localparam int SETS_W    = 5;
   localparam int LIDX_W    = 6;
   localparam int ELAPSED_W = 40;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 48;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_START_TIME   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_FRACTION = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RATE         = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP_ENABLE  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SET_COUNT    = 3'd4;

   // register reset values
   localparam logic [LEN_W-1:0]  START_TIME_RST   = 32'd0;
   localparam logic [FRAC_W-1:0] MIN_FRACTION_RST = 17'd32768;
   localparam logic [LEN_W-1:0]  RATE_RST         = 32'd65536;
   localparam logic [SETS_W-1:0] SET_COUNT_RST    = 5'd0;

   // item kind on req_tuser
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

endpackage

`default_nettype wire

// File: rtl/cable_retract_return_sequencer.sv
// cable_retract_return_sequencer: top level of the cable gait sequencer
// depends on crrs_pkg and crrs_ram (cable table storage)
//
// path: an accepted request item passes the table read stage (stage a) and then the
//   output register, whose valid drives rsp_tvalid
// throughput: one item per cycle while rsp_tready is high; each item does one table
//   ram read (plus one write for a load); a held result stalls the request side
// reset: synchronous, active high; clears config registers to defaults and the
//   sequencer state; the cable table is undefined until loaded, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module cable_retract_return_sequencer #(
   parameter int MAX_CABLES  = crrs_pkg::MAX_CABLES_DEF,
   parameter int TABLE_DEPTH = crrs_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // dt[15:0], current_length[47:16], initial_length[79:48],
   // load_index[85:80], load_cable[90:86], zero pad[95:91]
   input  wire logic [crrs_pkg::REQ_DATA_W-1:0] req_tdata,
   // func: 0 tick, 1 table load
   input  wire logic                            req_tuser,
   // result channel
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // cable[4:0], command_valid[5], command_length[37:6], cable_done[38],
   // next_cable[43:39], retracting[44], all_done[45], zero pad[47:46]
   output      logic [crrs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration write port
   input  wire logic                            csr_we,
   input  wire logic [crrs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [crrs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CABLE_W   = crrs_pkg::CABLE_W;
   localparam int LEN_W     = crrs_pkg::LEN_W;
   localparam int DT_W      = crrs_pkg::DT_W;
   localparam int FRAC_W    = crrs_pkg::FRAC_W;
   localparam int SETS_W    = crrs_pkg::SETS_W;
   localparam int LIDX_W    = crrs_pkg::LIDX_W;
   localparam int ELAPSED_W = crrs_pkg::ELAPSED_W;

   // table address width and helpers for modulo-depth index arithmetic
   localparam int              IDX_W      = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W:0]  DEPTH_C    = (IDX_W+1)'(TABLE_DEPTH);
   localparam logic [IDX_W:0]  SET_STRIDE = (IDX_W+1)'(4);
   localparam int              LCMP_W     = IDX_W + LIDX_W + 1;
   localparam logic [8:0]      CAB_MOD    = 9'(MAX_CABLES);
   localparam int              MOD_STEPS  = 8;

   // ---------------------------------------------------------------------
   // request field unpack
   // ---------------------------------------------------------------------
   logic [DT_W-1:0]    req_dt;
   logic [LEN_W-1:0]   req_current_length;
   logic [LEN_W-1:0]   req_initial_length;
   logic [LIDX_W-1:0]  req_load_index;
   logic [CABLE_W-1:0] req_load_cable;

   assign req_dt             = req_tdata[15:0];
   assign req_current_length = req_tdata[47:16];
   assign req_initial_length = req_tdata[79:48];
   assign req_load_index     = req_tdata[85:80];
   assign req_load_cable     = req_tdata[90:86];

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [LEN_W-1:0]  start_time_ff;
   logic [FRAC_W-1:0] min_fraction_ff;
   logic [LEN_W-1:0]  rate_ff;
   logic              loop_enable_ff;
   logic [SETS_W-1:0] set_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff   <= crrs_pkg::START_TIME_RST;
         min_fraction_ff <= crrs_pkg::MIN_FRACTION_RST;
         rate_ff         <= crrs_pkg::RATE_RST;
         loop_enable_ff  <= 1'b0;
         set_count_ff    <= crrs_pkg::SET_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            crrs_pkg::CSR_START_TIME:   start_time_ff   <= csr_wdata[LEN_W-1:0];
            crrs_pkg::CSR_MIN_FRACTION: min_fraction_ff <= csr_wdata[FRAC_W-1:0];
            crrs_pkg::CSR_RATE:         rate_ff         <= csr_wdata[LEN_W-1:0];
            crrs_pkg::CSR_LOOP_ENABLE:  loop_enable_ff  <= csr_wdata[0];
            crrs_pkg::CSR_SET_COUNT:    set_count_ff    <= csr_wdata[SETS_W-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // pipeline handshake
   // stage a holds the item whose table read is in flight; the output
   // register holds a finished result until the sink takes it
   // ---------------------------------------------------------------------
   logic a_valid_ff;
   logic rsp_valid_ff;
   logic a_move;
   logic req_fire;

   assign a_move     = a_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || a_move;
   assign req_fire   = req_tvalid && req_tready;

   // ---------------------------------------------------------------------
   // sequencer state
   // ---------------------------------------------------------------------
   logic [ELAPSED_W-1:0] elapsed_ff,  elapsed_in;
   logic                 retract_ff,  retract_in;
   logic                 finished_ff, finished_in;
   logic [1:0]           pos_ff,      pos_in;
   logic [SETS_W-1:0]    set_ff,      set_in;
   logic                 first_face_ff, first_face_in;
   // 4 * set_index modulo the table depth, kept alongside set_index
   logic [IDX_W-1:0]     base_ff,     base_in;

   // tick arithmetic
   logic [ELAPSED_W:0]         elapsed_sum;
   logic [ELAPSED_W-1:0]       elapsed_sat;
   logic                       running;
   logic [LEN_W+FRAC_W-1:0]    target_prod;
   logic [LEN_W:0]             target;
   logic                       above_target;
   logic                       below_initial;
   logic [LEN_W+DT_W-1:0]      step_prod;

   assign elapsed_sum   = {1'b0, elapsed_ff} + (ELAPSED_W+1)'(req_dt);
   assign elapsed_sat   = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];
   assign running       = (elapsed_sat > {8'd0, start_time_ff}) && !finished_ff;
   assign target_prod   = {{FRAC_W{1'b0}}, req_initial_length}
                        * {{LEN_W{1'b0}}, min_fraction_ff};
   // target above 32 bits behaves like a saturated target in this compare
   assign target        = target_prod[LEN_W+FRAC_W-1:16];
   assign above_target  = {1'b0, req_current_length} > target;
   assign below_initial = req_current_length < req_initial_length;
   assign step_prod     = {{DT_W{1'b0}}, rate_ff} * {{LEN_W{1'b0}}, req_dt};

   logic              is_tick;
   logic              tick_active;
   logic              cvalid_in;
   logic              cdone_in;
   logic [2:0]        pos_inc;
   logic [SETS_W:0]   set_inc;
   logic [IDX_W:0]    base_plus;
   logic [IDX_W-1:0]  base_step;

   assign is_tick     = req_fire && (req_tuser == crrs_pkg::FUNC_TICK);
   assign tick_active = is_tick && running;
   assign pos_inc     = {1'b0, pos_ff} + 3'd1;
   assign set_inc     = {1'b0, set_ff} + (SETS_W+1)'(1);
   assign base_plus   = {1'b0, base_ff} + SET_STRIDE;
   assign base_step   = (base_plus >= DEPTH_C) ? IDX_W'(base_plus - DEPTH_C)
                                               : base_plus[IDX_W-1:0];

   always_comb begin
      elapsed_in    = elapsed_ff;
      retract_in    = retract_ff;
      finished_in   = finished_ff;
      pos_in        = pos_ff;
      set_in        = set_ff;
      first_face_in = first_face_ff;
      base_in       = base_ff;
      cvalid_in     = 1'b0;
      cdone_in      = 1'b0;

      if (is_tick) begin
         elapsed_in = elapsed_sat;
      end

      if (tick_active) begin
         if (retract_ff) begin
            if (above_target) begin
               cvalid_in = 1'b1;
            end else begin
               cdone_in = 1'b1;
               // first face: three cables in, then return them
               if (pos_inc == 3'd3 && first_face_ff) begin
                  pos_in     = 2'd0;
                  retract_in = 1'b0;
               end else if (pos_inc == 3'd4) begin
                  // fourth cable returns in place
                  pos_in     = 2'd3;
                  retract_in = 1'b0;
               end else begin
                  pos_in = pos_inc[1:0];
               end
            end
         end else begin
            if (below_initial) begin
               cvalid_in = 1'b1;
            end else begin
               cdone_in = 1'b1;
               if (pos_inc == 3'd3) begin
                  // first face returned, go retract the fourth cable
                  pos_in        = 2'd3;
                  first_face_in = 1'b0;
                  retract_in    = 1'b1;
               end else if (pos_inc == 3'd4) begin
                  // set complete
                  pos_in        = 2'd0;
                  first_face_in = 1'b1;
                  retract_in    = 1'b1;
                  if (set_inc >= {1'b0, set_count_ff}) begin
                     if (loop_enable_ff) begin
                        set_in  = '0;
                        base_in = '0;
                     end else begin
                        set_in      = set_inc[SETS_W-1:0];
                        base_in     = (set_inc[SETS_W-1:0] == '0) ? '0 : base_step;
                        finished_in = 1'b1;
                     end
                  end else begin
                     set_in  = set_inc[SETS_W-1:0];
                     base_in = (set_inc[SETS_W-1:0] == '0) ? '0 : base_step;
                  end
               end else begin
                  pos_in = pos_inc[1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff    <= '0;
         retract_ff    <= 1'b1;
         finished_ff   <= 1'b0;
         pos_ff        <= '0;
         set_ff        <= '0;
         first_face_ff <= 1'b1;
         base_ff       <= '0;
      end else if (req_fire) begin
         elapsed_ff    <= elapsed_in;
         retract_ff    <= retract_in;
         finished_ff   <= finished_in;
         pos_ff        <= pos_in;
         set_ff        <= set_in;
         first_face_ff <= first_face_in;
         base_ff       <= base_in;
      end
   end

   // ---------------------------------------------------------------------
   // cable table: write on load, read the entry selected after this item
   // ---------------------------------------------------------------------
   logic [IDX_W:0]     idx_sum;
   logic [IDX_W-1:0]   idx_next;
   logic               load_in_range;
   logic               tbl_wr_en;
   logic [IDX_W-1:0]   tbl_wr_addr;
   logic [CABLE_W-1:0] tbl_wr_data;
   logic [CABLE_W-1:0] tbl_rd_data;
   logic [8:0]         cab_rem;

   assign idx_sum  = {1'b0, base_in} + (IDX_W+1)'(pos_in);
   assign idx_next = (idx_sum >= DEPTH_C) ? IDX_W'(idx_sum - DEPTH_C) : idx_sum[IDX_W-1:0];

   // cable number modulo the cable count, by repeated subtract on a narrow value
   always_comb begin
      cab_rem = 9'(req_load_cable);
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (cab_rem >= CAB_MOD) begin
            cab_rem = cab_rem - CAB_MOD;
         end
      end
   end

   assign load_in_range = LCMP_W'(req_load_index) < LCMP_W'(TABLE_DEPTH);
   assign tbl_wr_en     = req_fire && (req_tuser == crrs_pkg::FUNC_LOAD) && load_in_range;
   assign tbl_wr_addr   = IDX_W'(req_load_index);
   assign tbl_wr_data   = cab_rem[CABLE_W-1:0];

   crrs_ram #(
      .WIDTH (CABLE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (req_fire),
      .rd_addr (idx_next),
      .rd_data (tbl_rd_data)
   );

   // ---------------------------------------------------------------------
   // stage a: item waiting on its table read
   // ---------------------------------------------------------------------
   logic               a_cvalid_ff;
   logic               a_cdone_ff;
   logic               a_retract_op_ff;
   logic [LEN_W-1:0]   a_step_ff;
   logic [LEN_W-1:0]   a_cur_ff;
   logic               a_finished_ff;
   logic               a_retracting_ff;
   // load into the entry being read in the same cycle: ram returns old data
   logic               a_fwd_ff;
   logic [CABLE_W-1:0] a_fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_fire) begin
         a_valid_ff <= 1'b1;
      end else if (a_move) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_cvalid_ff     <= cvalid_in;
         a_cdone_ff      <= cdone_in;
         a_retract_op_ff <= retract_ff;
         a_step_ff       <= step_prod[LEN_W+DT_W-1:DT_W];
         a_cur_ff        <= req_current_length;
         a_finished_ff   <= finished_in;
         a_retracting_ff <= retract_in;
         a_fwd_ff        <= tbl_wr_en && (tbl_wr_addr == idx_next);
         a_fwd_data_ff   <= tbl_wr_data;
      end
   end

   // cable selected before the item in stage a
   logic [CABLE_W-1:0] last_next_ff;
   logic [CABLE_W-1:0] a_next;
   logic [LEN_W:0]     a_ret_sum;
   logic [LEN_W-1:0]   a_clen;

   assign a_next    = a_finished_ff ? '0 : (a_fwd_ff ? a_fwd_data_ff : tbl_rd_data);
   assign a_ret_sum = {1'b0, a_cur_ff} + {1'b0, a_step_ff};

   always_comb begin
      a_clen = '0;
      if (a_cvalid_ff) begin
         if (a_retract_op_ff) begin
            // retract saturates at zero
            a_clen = (a_step_ff >= a_cur_ff) ? '0 : a_cur_ff - a_step_ff;
         end else begin
            // return saturates at full scale
            a_clen = a_ret_sum[LEN_W] ? '1 : a_ret_sum[LEN_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------
   logic [crrs_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         last_next_ff <= '0;
      end else if (a_move) begin
         rsp_valid_ff <= 1'b1;
         last_next_ff <= a_next;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         rsp_data_ff <= {2'b00, a_finished_ff, a_retracting_ff, a_next,
                         a_cdone_ff, a_clen, a_cvalid_ff, last_next_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // position three is only reached on the second face of a set
   a_pos_face: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == 2'd3) |-> !first_face_ff)
      else $error("position 3 reached during first face");

   // once finished the sequencer stays finished until reset
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("finished flag cleared without reset");

   // a command never coincides with a done or with the finishing step
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[5] && (rsp_tdata[38] || rsp_tdata[45])))
      else $error("command issued together with done");

   // elapsed time only grows
   a_elapsed_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> elapsed_ff >= $past(elapsed_ff))
      else $error("elapsed time went backwards");

endmodule

`default_nettype wire

// File: rtl/crrs_ram.sv
// crrs_ram: generic single-write, single-read synchronous ram with a
// registered read port that holds its data when not enabled; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module crrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
